### rtl/archive_manifest_parser_assert.svh
// Assertion macros shared by the manifest parser modules.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef ARCHIVE_MANIFEST_PARSER_ASSERT_SVH
`define ARCHIVE_MANIFEST_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AMP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("manifest parser: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define AMP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("manifest parser: next-cycle check failed");

`endif

### rtl/amp_pkg.sv
package amp_pkg;

	// Parser phases, in the order the manifest is laid out.
	typedef enum logic [2:0] {
		PH_COUNT,
		PH_PLEN,
		PH_PATH,
		PH_SIZE,
		PH_MTIME,
		PH_MODE,
		PH_CRC,
		PH_IDLE
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PATH,
		KIND_ENTRY,
		KIND_DONE,
		KIND_ERROR
	} kind_t;

	typedef enum logic [1:0] {
		ERR_TRUNC,
		ERR_COUNT,
		ERR_PATH_LEN
	} err_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_MAX_ENTRIES,
		REG_MAX_PATH_LEN
	} reg_idx_t;

	localparam logic [19:0] MaxEntriesRst = 20'd200000;
	localparam logic [15:0] MaxPathLenRst = 16'd4096;
	localparam logic [29:0] CountMax      = 30'h3FFF_FFFF;
	localparam int          OutqDepth     = 4;

	typedef struct packed {
		logic [19:0] max_entries;
		logic [15:0] max_path_len;
	} cfg_t;

	// One result item.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  path_byte;
		logic [15:0] path_length;
		logic [63:0] size;
		logic [63:0] mtime;
		logic [31:0] mode;
		logic [31:0] crc;
		logic [29:0] consumed;
		err_t        err;
		logic        last;
	} res_t;

	// Up to two results written into the output queue in one cycle.
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

### rtl/amp_parse.sv
module amp_parse import amp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_eob,
	input  cfg_t        cfg,
	input  logic        room,
	output push_t       push
);

`include "archive_manifest_parser_assert.svh"

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eob_s1;
	logic        advance;

	phase_t      phase_q, phase_d;
	logic [2:0]  idx_q, idx_d;
	logic [63:0] field_q, field_d;
	logic [19:0] entries_q, entries_d;
	logic [15:0] plen_q, plen_d;
	logic [15:0] pleft_q, pleft_d;
	logic [63:0] size_q, size_d;
	logic [63:0] mtime_q, mtime_d;
	logic [31:0] mode_q, mode_d;
	logic [29:0] bcount_q, bcount_d;

	// The input register is refilled whenever its item moves on.
	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			byte_s1 <= in_byte;
			eob_s1  <= in_eob;
		end
	end

	// One byte of parsing: next state and the results it causes.
	always_comb begin
		logic [63:0] fval;
		logic [2:0]  last_idx;
		logic        fdone;
		logic [29:0] cnt;
		logic        v0, v1, v2;
		res_t        p0, p1, p2, blank;

		blank      = '0;
		p0         = blank;
		p1         = blank;
		p2         = blank;
		v0         = 1'b0;
		v1         = 1'b0;
		v2         = 1'b0;
		phase_d    = phase_q;
		idx_d      = idx_q;
		field_d    = field_q;
		entries_d  = entries_q;
		plen_d     = plen_q;
		pleft_d    = pleft_q;
		size_d     = size_q;
		mtime_d    = mtime_q;
		mode_d     = mode_q;
		bcount_d   = bcount_q;

		fval = field_q | (64'(byte_s1) << {idx_q, 3'b000});
		case (phase_q)
			PH_COUNT:             last_idx = 3'd3;
			PH_PLEN:              last_idx = 3'd1;
			PH_SIZE, PH_MTIME:    last_idx = 3'd7;
			PH_MODE, PH_CRC:      last_idx = 3'd3;
			default:              last_idx = 3'd0;
		endcase
		fdone = (idx_q == last_idx);
		cnt   = (bcount_q < CountMax) ? bcount_q + 30'd1 : bcount_q;

		if (advance && phase_q != PH_IDLE) begin
			bcount_d = cnt;
			// Little-endian field gathering shared by the multi-byte phases.
			if (phase_q != PH_PATH) begin
				if (fdone) begin
					idx_d   = 3'd0;
					field_d = '0;
				end else begin
					idx_d   = idx_q + 3'd1;
					field_d = fval;
				end
			end
			case (phase_q)
				PH_COUNT: begin
					if (fdone) begin
						if (fval[31:0] > {12'd0, cfg.max_entries}) begin
							v0       = 1'b1;
							p0.kind  = KIND_ERROR;
							p0.err   = ERR_COUNT;
							phase_d  = PH_IDLE;
						end else if (fval[31:0] == 32'd0) begin
							v0          = 1'b1;
							p0.kind     = KIND_DONE;
							p0.consumed = cnt;
							phase_d     = PH_IDLE;
						end else begin
							entries_d = fval[19:0];
							phase_d   = PH_PLEN;
						end
					end
				end
				PH_PLEN: begin
					if (fdone) begin
						if (fval[15:0] == 16'd0 || fval[15:0] > cfg.max_path_len) begin
							v0      = 1'b1;
							p0.kind = KIND_ERROR;
							p0.err  = ERR_PATH_LEN;
							phase_d = PH_IDLE;
						end else begin
							plen_d  = fval[15:0];
							pleft_d = fval[15:0];
							phase_d = PH_PATH;
						end
					end
				end
				PH_PATH: begin
					v0           = 1'b1;
					p0.kind      = KIND_PATH;
					p0.path_byte = byte_s1;
					pleft_d      = pleft_q - 16'd1;
					if (pleft_q == 16'd1) begin
						phase_d = PH_SIZE;
					end
				end
				PH_SIZE: begin
					if (fdone) begin
						size_d  = fval;
						phase_d = PH_MTIME;
					end
				end
				PH_MTIME: begin
					if (fdone) begin
						mtime_d = fval;
						phase_d = PH_MODE;
					end
				end
				PH_MODE: begin
					if (fdone) begin
						mode_d  = fval[31:0];
						phase_d = PH_CRC;
					end
				end
				default: begin
					if (fdone) begin
						v0             = 1'b1;
						p0.kind        = KIND_ENTRY;
						p0.path_length = plen_q;
						p0.size        = size_q;
						p0.mtime       = mtime_q;
						p0.mode        = mode_q;
						p0.crc         = fval[31:0];
						entries_d      = entries_q - 20'd1;
						if (entries_q == 20'd1) begin
							v1          = 1'b1;
							p1.kind     = KIND_DONE;
							p1.consumed = cnt;
							phase_d     = PH_IDLE;
						end else begin
							phase_d = PH_PLEN;
						end
					end
				end
			endcase
		end

		// The end mark restarts the parser, reporting truncation if unfinished.
		if (advance && eob_s1) begin
			if (phase_d != PH_IDLE) begin
				v2      = 1'b1;
				p2.kind = KIND_ERROR;
				p2.err  = ERR_TRUNC;
			end
			phase_d   = PH_COUNT;
			idx_d     = '0;
			field_d   = '0;
			entries_d = '0;
			plen_d    = '0;
			pleft_d   = '0;
			size_d    = '0;
			mtime_d   = '0;
			mode_d    = '0;
			bcount_d  = '0;
		end

		push.r0 = v0 ? p0 : p2;
		push.r1 = v1 ? p1 : p2;
		push.n  = {1'b0, v0} + {1'b0, v1 | v2};
		if (push.n == 2'd2) begin
			push.r1.last = 1'b1;
		end else begin
			push.r0.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_COUNT;
			idx_q     <= '0;
			field_q   <= '0;
			entries_q <= '0;
			plen_q    <= '0;
			pleft_q   <= '0;
			size_q    <= '0;
			mtime_q   <= '0;
			mode_q    <= '0;
			bcount_q  <= '0;
		end else begin
			phase_q   <= phase_d;
			idx_q     <= idx_d;
			field_q   <= field_d;
			entries_q <= entries_d;
			plen_q    <= plen_d;
			pleft_q   <= pleft_d;
			size_q    <= size_d;
			mtime_q   <= mtime_d;
			mode_q    <= mode_d;
			bcount_q  <= bcount_d;
		end
	end

	// Once idle, bytes give nothing until the end mark.
	`AMP_ASSERT_SAME(a_idle_silent, advance && phase_q == PH_IDLE, push.n == 2'd0)
	// Results only leave with an item that really moved on.
	`AMP_ASSERT_SAME(a_push_needs_item, push.n != 2'd0, advance)
	// The end mark always leaves the parser at the start of a new manifest.
	`AMP_ASSERT_NEXT(a_eob_restart, advance && eob_s1,
		phase_q == PH_COUNT && bcount_q == 30'd0)

endmodule

### rtl/amp_outq.sv
module amp_outq import amp_pkg::*; #(
	parameter int DEPTH = OutqDepth
) (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  head_valid,
	input  logic  head_ready,
	output res_t  head
);

`include "archive_manifest_parser_assert.svh"

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

	res_t          mem [DEPTH];
	logic [AW-1:0] wr_q, rd_q, wr1, wr2, rd1;
	logic [CW-1:0] count_q;
	logic          pop;

	assign wr1 = (wr_q == LAST_C) ? '0 : wr_q + AW'(1);
	assign wr2 = (wr1 == LAST_C) ? '0 : wr1 + AW'(1);
	assign rd1 = (rd_q == LAST_C) ? '0 : rd_q + AW'(1);

	// Room is judged on the registered fill so that two results always fit.
	assign room       = (count_q <= DEPTH_C - CW'(2));
	assign head_valid = (count_q != '0);
	assign pop        = head_valid && head_ready;
	assign head       = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem[wr1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			case (push.n)
				2'd1:    wr_q <= wr1;
				2'd2:    wr_q <= wr2;
				default: wr_q <= wr_q;
			endcase
			if (pop) begin
				rd_q <= rd1;
			end
			count_q <= count_q + CW'(push.n) - CW'(pop);
		end
	end

	`AMP_ASSERT_SAME(a_no_overflow, 1'b1, count_q <= DEPTH_C)
	`AMP_ASSERT_SAME(a_push_fits, push.n != 2'd0, room)
	`AMP_ASSERT_SAME(a_room_when_empty, count_q == '0, room)

endmodule

### rtl/archive_manifest_parser.sv
// An accepted byte waits in the input register; its results go into the output queue as it moves on.
// Throughput: one byte per cycle while the queue has room; one result leaves per cycle while m_tready is high.
// Input stalls while the queue holds more than OUTQ_DEPTH - 2 results, keeping room for a byte with two.
// Reset: arst_n clears the parser to the start of a manifest and empties the queue.
// Reset also loads max_entries with 200000 and max_path_len with 4096.
module archive_manifest_parser import amp_pkg::*; #(
	parameter int OUTQ_DEPTH = OutqDepth
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// path_byte, path_length, entry_size, entry_mtime, entry_mode, entry_crc,
	// consumed_bytes, fault_code
	output logic [247:0] m_tdata,
	output logic [1:0]   m_tuser,   // result_kind
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [19:0]  cfg_data
);

	cfg_t  cfg_q;
	push_t push;
	logic  room;
	res_t  head;

	// Configuration registers, always writable.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_entries  <= MaxEntriesRst;
			cfg_q.max_path_len <= MaxPathLenRst;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_MAX_ENTRIES:  cfg_q.max_entries  <= cfg_data;
				REG_MAX_PATH_LEN: cfg_q.max_path_len <= cfg_data[15:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	amp_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_eob   (s_tlast),
		.cfg      (cfg_q),
		.room     (room),
		.push     (push)
	);

	amp_outq #(
		.DEPTH (OUTQ_DEPTH)
	) u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.head_valid (m_tvalid),
		.head_ready (m_tready),
		.head       (head)
	);

	// Result item packing onto the stream.
	assign m_tdata = {head.err, head.consumed, head.crc, head.mode, head.mtime,
		head.size, head.path_length, head.path_byte};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule
